// ----- rtl/jfs_pkg.sv -----
// shared constants and types for the jacobi five-point stencil core
package jfs_pkg;

  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_MAX_HEIGHT  = 4096;
  localparam int DEF_SAMPLE_BITS = 16;

  // grid size after reset, and the smallest grid in use
  localparam int RST_GRID_WIDTH  = 1024;
  localparam int RST_GRID_HEIGHT = 1024;
  localparam int MIN_GRID        = 3;

  // result queue depth, room for two results per transfer plus slack
  localparam int FIFO_DEPTH = 4;

  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  // results written into the queue by one input transfer
  typedef struct packed {
    logic push;  // first result present
    logic pair;  // second result present as well
  } jfs_push_t;

endpackage

// ----- rtl/jfs_stencil.sv -----
// line buffers, raster counters and the five-point update for one arriving cell
module jfs_stencil
  import jfs_pkg::*;
#(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int COL_W = $clog2(MAX_WIDTH),
  localparam int ROW_W = $clog2(MAX_HEIGHT),
  localparam int RES_W = SAMPLE_BITS + ROW_W + COL_W + 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   restart,
  input  logic [COL_W-1:0]       w_last,
  input  logic [ROW_W-1:0]       h_last,
  input  logic                   accept,
  input  logic [SAMPLE_BITS-1:0] x,
  output jfs_push_t              push,
  output logic [RES_W-1:0]       data_a,
  output logic [RES_W-1:0]       data_b
);

  logic [SAMPLE_BITS-1:0] prev_mem  [MAX_WIDTH];
  logic [SAMPLE_BITS-1:0] prev2_mem [MAX_WIDTH];

  logic [COL_W-1:0]       col_r;
  logic [ROW_W-1:0]       row_r;
  logic [SAMPLE_BITS-1:0] mid_r;     // row r-1 at the pending column
  logic [SAMPLE_BITS-1:0] left_r;    // row r-1 at the column before
  logic [SAMPLE_BITS-1:0] col0_r;    // current row, columns 0 and 1, for the next row start
  logic [SAMPLE_BITS-1:0] col1_r;
  logic [SAMPLE_BITS-1:0] q_prev_r;  // row r-1 at pending column + 1
  logic [SAMPLE_BITS-1:0] q_prev2_r; // row r-2 at pending column

  logic                   col_end;
  logic                   row_end;
  logic                   interior;
  logic [SAMPLE_BITS-1:0] right_cur;
  logic [SAMPLE_BITS+1:0] sum;
  logic [SAMPLE_BITS-1:0] val;
  logic [COL_W:0]         rd_prev_ext;
  logic [COL_W-1:0]       rd_prev_addr;
  logic [COL_W-1:0]       rd_prev2_addr;
  logic [ROW_W-1:0]       row_m1;

  always_comb begin
    col_end   = (col_r == w_last);
    row_end   = (row_r == h_last);
    interior  = (row_r >= ROW_W'(2)) && (col_r != '0) && !col_end;
    // at column 0 the right neighbor comes from the register, the read was a row wrap
    right_cur = (col_r == '0) ? col1_r : q_prev_r;
    sum = {2'b00, q_prev2_r} + {2'b00, x} + {2'b00, left_r} + {2'b00, right_cur};
    val = interior ? sum[SAMPLE_BITS+1:2] : mid_r;
    rd_prev_ext   = {1'b0, col_r} + (COL_W+1)'(2);
    rd_prev_addr  = (rd_prev_ext <= {1'b0, w_last}) ? rd_prev_ext[COL_W-1:0] : '0;
    rd_prev2_addr = col_end ? '0 : col_r + COL_W'(1);
    row_m1 = row_r - ROW_W'(1);
    push.push = accept && (row_r != '0);
    push.pair = accept && row_end;
    data_a = {val, row_m1, col_r, !row_end};
    data_b = {x, row_r, col_r, 1'b1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (restart) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      if (col_end) begin
        col_r <= '0;
        row_r <= row_end ? '0 : row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  // prefetch for the next column: its right neighbor and its row r-2 value
  always_ff @(posedge clk) begin
    if (accept) begin
      prev_mem[col_r]  <= x;
      prev2_mem[col_r] <= mid_r;
      q_prev_r         <= prev_mem[rd_prev_addr];
      q_prev2_r        <= prev2_mem[rd_prev2_addr];
      left_r           <= mid_r;
      mid_r            <= col_end ? col0_r : right_cur;
      if (col_r == '0) begin
        col0_r <= x;
      end
      if (col_r == COL_W'(1)) begin
        col1_r <= x;
      end
    end
  end

endmodule

// ----- rtl/jfs_out_fifo.sv -----
// small result queue that takes one or two results per cycle and gives one per cycle while out_ready is high
module jfs_out_fifo
  import jfs_pkg::*;
#(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  jfs_push_t     push,
  input  logic [DW-1:0] data_a,
  input  logic [DW-1:0] data_b,
  output logic          room,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [DW-1:0] out_data
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  logic [DW-1:0]  entry_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wp_r;
  logic [PTR_W-1:0] rp_r;
  logic [PTR_W:0]   cnt_r;
  logic [PTR_W:0]   cnt_nxt;
  logic             pop;

  always_comb begin
    out_valid = (cnt_r != '0);
    pop       = out_valid && out_ready;
    out_data  = entry_r[rp_r];
    // two free entries are needed, a cell may bring two results
    room      = (cnt_r <= (PTR_W+1)'(FIFO_DEPTH - 2));
    cnt_nxt   = cnt_r + (PTR_W+1)'(push.push) + (PTR_W+1)'(push.pair) - (PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + PTR_W'(push.push) + PTR_W'(push.pair);
      rp_r  <= rp_r + PTR_W'(pop);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push) begin
      entry_r[wp_r] <= data_a;
    end
    if (push.pair) begin
      entry_r[wp_r + PTR_W'(1)] <= data_b;
    end
  end

endmodule

// ----- rtl/jacobi_five_point_stencil_core.sv -----
// Jacobi five-point stencil core: one sweep of a 2D heat grid, cells in raster order.
// An arriving cell of row r finishes the cell above it, so results come out one row
// behind, each tagged with its row and column; the last row also gives back its own
// cells, two results for one transfer. Throughput is one cell per cycle while the
// four-entry result queue has room for two results; in the last row the single result
// port sets the pace, as each cell gives two results. A result is registered in the
// result queue before it shows. Line buffers are two arrays of MAX_WIDTH samples,
// each with one write and one read per cell, read ahead of use; they need no clearing
// after reset. A register write restarts the sweep at row 0, column 0 and keeps the
// buffers. Width and height are clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT.
module jacobi_five_point_stencil_core
  import jfs_pkg::*;
#(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int COL_W = $clog2(MAX_WIDTH),
  localparam int ROW_W = $clog2(MAX_HEIGHT),
  localparam int GW_W  = $clog2(MAX_WIDTH + 1),
  localparam int GH_W  = $clog2(MAX_HEIGHT + 1),
  localparam int CFG_W = (GW_W > GH_W) ? GW_W : GH_W
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_temp_in,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] out_temp_out,
  output logic [ROW_W-1:0]       out_row,
  output logic [COL_W-1:0]       out_col,
  output logic                   out_last_of_run
);

  localparam int RES_W = SAMPLE_BITS + ROW_W + COL_W + 1;
  localparam int RST_W = (RST_GRID_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_GRID_WIDTH;
  localparam int RST_H = (RST_GRID_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_GRID_HEIGHT;

  logic [COL_W-1:0] w_last_r;
  logic [ROW_W-1:0] h_last_r;
  logic [COL_W-1:0] w_last_nxt;
  logic [ROW_W-1:0] h_last_nxt;
  logic [GW_W-1:0]  gw;
  logic [GH_W-1:0]  gh;
  logic             cfg_wr;
  logic             accept;
  logic             room;
  jfs_push_t        push;
  logic [RES_W-1:0] data_a;
  logic [RES_W-1:0] data_b;
  logic [RES_W-1:0] out_data;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_ready  = room;
  assign accept    = in_valid && in_ready;
  assign {out_temp_out, out_row, out_col, out_last_of_run} = out_data;

  // clamp the written size and keep it as the index of the last column or row
  always_comb begin
    gw = cfg_data[GW_W-1:0];
    gh = cfg_data[GH_W-1:0];
    if (gw < GW_W'(MIN_GRID)) begin
      w_last_nxt = COL_W'(MIN_GRID - 1);
    end else if (gw > GW_W'(MAX_WIDTH)) begin
      w_last_nxt = COL_W'(MAX_WIDTH - 1);
    end else begin
      w_last_nxt = COL_W'(gw - GW_W'(1));
    end
    if (gh < GH_W'(MIN_GRID)) begin
      h_last_nxt = ROW_W'(MIN_GRID - 1);
    end else if (gh > GH_W'(MAX_HEIGHT)) begin
      h_last_nxt = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      h_last_nxt = ROW_W'(gh - GH_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r <= COL_W'(RST_W - 1);
      h_last_r <= ROW_W'(RST_H - 1);
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  w_last_r <= w_last_nxt;
        REG_GRID_HEIGHT: h_last_r <= h_last_nxt;
        default: ;
      endcase
    end
  end

  jfs_stencil #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_stencil (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (cfg_wr),
    .w_last  (w_last_r),
    .h_last  (h_last_r),
    .accept  (accept),
    .x       (in_temp_in),
    .push    (push),
    .data_a  (data_a),
    .data_b  (data_b)
  );

  jfs_out_fifo #(
    .DW (RES_W)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .data_a    (data_a),
    .data_b    (data_b),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/jfs_assert.sv -----
// port-level checks for the stencil core, bound to the top level
module jfs_assert #(
  parameter int SAMPLE_BITS = 16,
  parameter int ROW_W = 12,
  parameter int COL_W = 10
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_temp_out,
  input logic [ROW_W-1:0]       out_row,
  input logic [COL_W-1:0]       out_col,
  input logic                   out_last_of_run
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_temp_out) && $stable(out_row)
      && $stable(out_col) && $stable(out_last_of_run))
    else $error("result changed while stalled");

  // the second result of a cell is already queued, one row down in the same column
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_run |=> out_valid && out_last_of_run
      && out_row == ROW_W'($past(out_row) + 1'b1) && out_col == $past(out_col))
    else $error("second result of a cell missing or misplaced");

  // an empty queue always has room
  a_empty_room: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty result queue");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind jacobi_five_point_stencil_core jfs_assert #(
  .SAMPLE_BITS (SAMPLE_BITS),
  .ROW_W       (ROW_W),
  .COL_W       (COL_W)
) u_jfs_assert (.*);
